[rtl/bfd_pkg.sv]
package bfd_pkg;

  localparam int DIGIT_W = 4;
  localparam int BCD_W   = 5;
  localparam int CNT_IN_W = 7;

  localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 4'd1;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [BCD_W-1:0]   BCD_NINE   = 5'd9;
  localparam logic [BCD_W-1:0]   BCD_TEN    = 5'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } bfd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new transaction, restart the digit stores
    logic step;   // one add-and-halve pass for the current mantissa bit
    logic next;   // advance to the next output digit
  } bfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;  // current pass handles mantissa bit 0
    logic emit_last;  // current output digit is the final one
  } bfd_status_t;

endpackage

[rtl/bfd_datapath.sv]
module bfd_datapath import bfd_pkg::*; #(
  parameter int MANT_WIDTH      = 64,
  parameter int FRACTION_DIGITS = 63
) (
  input  logic                   clk_i,
  input  bfd_cmd_t               cmd_i,
  output bfd_status_t            status_o,
  input  logic [MANT_WIDTH-1:0]  mantissa_i,
  input  logic [CNT_IN_W-1:0]    bit_count_i,
  output logic [DIGIT_W-1:0]     digit_o,
  output logic                   is_integer_digit_o,
  output logic                   last_o
);

  localparam int NDIG = FRACTION_DIGITS + 1;
  localparam int NMAX = (MANT_WIDTH < NDIG) ? MANT_WIDTH : NDIG;
  localparam int KW   = $clog2(NDIG);
  localparam int SW   = $clog2(MANT_WIDTH);
  localparam int LV   = $clog2(NDIG);

  logic [DIGIT_W-1:0]    sum_q [NDIG];
  logic [DIGIT_W-1:0]    sum_d [NDIG];
  logic [DIGIT_W-1:0]    pow_q [NDIG];
  logic [DIGIT_W-1:0]    pow_d [NDIG];
  logic [MANT_WIDTH-1:0] mant_q;
  logic [KW-1:0]         cnt_q;
  logic [KW-1:0]         nm1_q;
  logic [KW-1:0]         k_q;

  logic [KW-1:0]         nm1;
  logic [SW-1:0]         shamt;

  // Generate / propagate per level, indexed by significance (0 = least).
  logic                  gen_l [LV+1][NDIG];
  logic                  prp_l [LV+1][NDIG];
  logic [BCD_W-1:0]      pair  [NDIG];
  logic [BCD_W-1:0]      tot   [NDIG];
  logic                  cin   [NDIG];

  // Clamp the bit count to 1..NMAX and left-align the used mantissa bits.
  always_comb begin
    if (bit_count_i == '0) begin
      nm1 = '0;
    end else if (bit_count_i > CNT_IN_W'(NMAX)) begin
      nm1 = KW'(NMAX - 1);
    end else begin
      nm1 = KW'(bit_count_i - CNT_IN_W'(1));
    end
    shamt = SW'(MANT_WIDTH - 1) - SW'(nm1);
  end

  // Decimal add with parallel-prefix carry, then digit-wise halving.
  always_comb begin
    for (int j = 0; j < NDIG; j++) begin
      pair[j] = BCD_W'(sum_q[NDIG-1-j]) + BCD_W'(pow_q[NDIG-1-j]);
      gen_l[0][j] = pair[j] > BCD_NINE;
      prp_l[0][j] = pair[j] == BCD_NINE;
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < NDIG; j++) begin
        if (j >= (1 << l)) begin
          gen_l[l+1][j] = gen_l[l][j] | (prp_l[l][j] & gen_l[l][j-(1<<l)]);
          prp_l[l+1][j] = prp_l[l][j] & prp_l[l][j-(1<<l)];
        end else begin
          gen_l[l+1][j] = gen_l[l][j];
          prp_l[l+1][j] = prp_l[l][j];
        end
      end
    end
    for (int j = 0; j < NDIG; j++) begin
      cin[j] = (j == 0) ? 1'b0 : gen_l[LV][j-1];
      tot[j] = pair[j] + BCD_W'(cin[j]);
    end
    for (int k = 0; k < NDIG; k++) begin
      if (mant_q[MANT_WIDTH-1]) begin
        sum_d[k] = (tot[NDIG-1-k] > BCD_NINE) ? DIGIT_W'(tot[NDIG-1-k] - BCD_TEN)
                                               : DIGIT_W'(tot[NDIG-1-k]);
      end else begin
        sum_d[k] = sum_q[k];
      end
      pow_d[k] = (pow_q[k] >> 1) +
                 (((k > 0) && pow_q[(k > 0) ? k-1 : 0][0]) ? DIGIT_FIVE : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < NDIG; k++) begin
        sum_q[k] <= '0;
        pow_q[k] <= (k == 0) ? DIGIT_ONE : '0;
      end
      mant_q <= mantissa_i << shamt;
      cnt_q  <= nm1;
      nm1_q  <= nm1;
      k_q    <= '0;
    end else if (cmd_i.step) begin
      sum_q  <= sum_d;
      // Skip the halving after bit 0: the power is not used again.
      if (cnt_q != '0) begin
        pow_q <= pow_d;
      end
      mant_q <= mant_q << 1;
      cnt_q  <= cnt_q - KW'(1);
    end else if (cmd_i.next) begin
      k_q <= k_q + KW'(1);
    end
  end

  assign status_o.step_last  = (cnt_q == '0);
  assign status_o.emit_last  = (k_q == nm1_q);
  assign digit_o             = sum_q[k_q];
  assign is_integer_digit_o  = (k_q == '0);
  assign last_o              = (k_q == nm1_q);

endmodule

[rtl/bfd_ctrl.sv]
module bfd_ctrl import bfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bfd_cmd_t    cmd_o,
  input  bfd_status_t status_i
);

  bfd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (status_i.step_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.next = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/binary_fraction_to_decimal.sv]
// Flow: after capture, n add-and-halve passes run over the digit registers,
// n = clamped bit count, then the n digits drain one per cycle while
// m_axis_tready_i is high. A new transaction is accepted only after the last
// digit of the previous one has been taken.
// Reset: rst_ni is asynchronous and active low; it returns the controller to
// idle, ready for a new transaction. Digit registers are reloaded per item.
module binary_fraction_to_decimal import bfd_pkg::*; #(
  parameter int MANT_WIDTH      = 64,
  parameter int FRACTION_DIGITS = 63
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Input stream. tdata, low bit up: mantissa [MANT_WIDTH], bit_count [7], zero fill.
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  logic [((MANT_WIDTH+CNT_IN_W+7)/8)*8-1:0]   s_axis_tdata_i,

  // Output stream. tdata, low bit up: digit [4], zero fill.
  // tuser: is_integer_digit [1]. tlast: last digit of the run.
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  output logic [7:0]                                 m_axis_tdata_o,
  output logic                                       m_axis_tuser_o,
  output logic                                       m_axis_tlast_o
);

  bfd_cmd_t           cmd;
  bfd_status_t        status;
  logic [DIGIT_W-1:0] digit;

  // Sequence the transaction: capture, n passes, then drain digits.
  bfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Hold the decimal accumulator and power registers and the bit counters.
  bfd_datapath #(
    .MANT_WIDTH      (MANT_WIDTH),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .mantissa_i         (s_axis_tdata_i[MANT_WIDTH-1:0]),
    .bit_count_i        (s_axis_tdata_i[MANT_WIDTH+CNT_IN_W-1:MANT_WIDTH]),
    .digit_o            (digit),
    .is_integer_digit_o (m_axis_tuser_o),
    .last_o             (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(8-DIGIT_W){1'b0}}, digit};

endmodule
